### rtl/core/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// rau_pkg: shared types and constants of the rational arithmetic unit
// no dependencies; used by rau_front, rau_back, rational_arithmetic_unit and the testbench

package rau_pkg;

    // fixed field widths of the request and result ports
    localparam int CMD_W = 3;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_INC = 3'd4,
        CMD_DEC = 3'd5
    } rau_cmd_t;

    // front sequencer states
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_MUL,
        FR_FORM,
        FR_PUSH
    } rau_front_state_t;

    // back sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_GCD,
        BK_DIV,
        BK_DONE
    } rau_back_state_t;

    // per-request status carried through the queue
    typedef struct packed {
        logic neg;
        logic zdiv;
        logic first_less;
        logic both_equal;
    } rau_flags_t;

endpackage

`default_nettype wire

### rtl/core/rau_front.sv
`timescale 1ns / 1ps
`default_nettype none
// rau_front: accepts a request, forms the raw fraction and the comparison
// with one shared multiplier; depends on rau_pkg

module rau_front
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [CMD_W-1:0]           s_command,
    input  wire logic [NUM_W-1:0]           s_a_num,
    input  wire logic [DEN_W-1:0]           s_a_den,
    input  wire logic [NUM_W-1:0]           s_b_num,
    input  wire logic [DEN_W-1:0]           s_b_den,
    output logic                            push,
    input  wire logic                       q_full,
    output logic [2*VALUE_WIDTH-1:0]        push_mag,
    output logic [2*VALUE_WIDTH-1:0]        push_dmag,
    output rau_flags_t                      push_flags
);

    localparam int PROD_W = 2 * VALUE_WIDTH;
    localparam logic [VALUE_WIDTH-2:0] DEN_ONE = {{(VALUE_WIDTH-2){1'b0}}, 1'b1};
    localparam logic signed [PROD_W-1:0] PROD_ONE = {{(PROD_W-1){1'b0}}, 1'b1};

    rau_front_state_t state_reg, state_next;
    logic [1:0]       step_reg, step_next;

    logic [CMD_W-1:0]              cmd_reg;
    logic signed [VALUE_WIDTH-1:0] an_reg, bn_reg;
    logic [VALUE_WIDTH-2:0]        ad_reg, bd_reg;
    logic signed [PROD_W-1:0]      lhs_reg, rhs_reg, dd_reg, p3_reg;
    logic signed [PROD_W-1:0]      rn_reg, rd_reg;
    logic                          less_reg, equal_reg;

    logic                          load_in, mul_en, form_en;
    logic signed [VALUE_WIDTH-1:0] in_an, in_bn;
    logic [VALUE_WIDTH-2:0]        in_ad, in_bd;
    logic signed [VALUE_WIDTH-1:0] ad_ext, bd_ext;
    logic signed [VALUE_WIDTH-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [PROD_W-1:0]      rn_comb, rd_comb;

    // operand extraction: low bits of each field, zero denominator read as one
    always_comb begin
        in_an = s_a_num[VALUE_WIDTH-1:0];
        in_bn = s_b_num[VALUE_WIDTH-1:0];
        in_ad = (s_a_den[VALUE_WIDTH-2:0] == '0) ? DEN_ONE : s_a_den[VALUE_WIDTH-2:0];
        in_bd = (s_b_den[VALUE_WIDTH-2:0] == '0) ? DEN_ONE : s_b_den[VALUE_WIDTH-2:0];
    end

    assign ad_ext = signed'({1'b0, ad_reg});
    assign bd_ext = signed'({1'b0, bd_reg});

    // shared multiplier operand select, one product per step
    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = an_reg;
                mul_b = bd_ext;
            end
            2'd1: begin
                mul_a = bn_reg;
                mul_b = ad_ext;
            end
            2'd2: begin
                mul_a = ad_ext;
                mul_b = bd_ext;
            end
            default: begin
                mul_a = (cmd_reg == CMD_DIV) ? ad_ext : an_reg;
                mul_b = bn_reg;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // raw numerator and denominator per command
    always_comb begin
        unique case (cmd_reg)
            CMD_ADD: begin
                rn_comb = lhs_reg + rhs_reg;
                rd_comb = dd_reg;
            end
            CMD_SUB: begin
                rn_comb = lhs_reg - rhs_reg;
                rd_comb = dd_reg;
            end
            CMD_MUL: begin
                rn_comb = p3_reg;
                rd_comb = dd_reg;
            end
            CMD_DIV: begin
                rn_comb = lhs_reg;
                rd_comb = p3_reg;
            end
            CMD_INC: begin
                rn_comb = PROD_W'(an_reg) + PROD_W'(ad_ext);
                rd_comb = PROD_W'(ad_ext);
            end
            CMD_DEC: begin
                rn_comb = PROD_W'(an_reg) - PROD_W'(ad_ext);
                rd_comb = PROD_W'(ad_ext);
            end
            default: begin
                rn_comb = '0;
                rd_comb = PROD_ONE;
            end
        endcase
    end

    // sign and magnitude of the raw fraction for the queue
    always_comb begin
        push_mag             = rn_reg[PROD_W-1] ? unsigned'(-rn_reg) : unsigned'(rn_reg);
        push_dmag            = rd_reg[PROD_W-1] ? unsigned'(-rd_reg) : unsigned'(rd_reg);
        push_flags.neg        = rn_reg[PROD_W-1] ^ rd_reg[PROD_W-1];
        push_flags.zdiv       = (rd_reg == '0);
        push_flags.first_less = less_reg;
        push_flags.both_equal = equal_reg;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            FR_IDLE: begin
                step_next = 2'd0;
                if (s_valid) begin
                    state_next = FR_MUL;
                end
            end
            FR_MUL: begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3) begin
                    state_next = FR_FORM;
                end
            end
            FR_FORM: begin
                state_next = FR_PUSH;
            end
            FR_PUSH: begin
                if (!q_full) begin
                    state_next = FR_IDLE;
                end
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    // outputs and enables
    always_comb begin
        s_ready = (state_reg == FR_IDLE);
        load_in = s_valid && (state_reg == FR_IDLE);
        mul_en  = (state_reg == FR_MUL);
        form_en = (state_reg == FR_FORM);
        push    = (state_reg == FR_PUSH) && !q_full;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_IDLE;
            step_reg  <= 2'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // operand, product and fraction registers
    always_ff @(posedge aclk) begin
        if (load_in) begin
            cmd_reg <= s_command;
            an_reg  <= in_an;
            bn_reg  <= in_bn;
            ad_reg  <= in_ad;
            bd_reg  <= in_bd;
        end
        if (mul_en) begin
            case (step_reg)
                2'd0:    lhs_reg <= prod;
                2'd1:    rhs_reg <= prod;
                2'd2:    dd_reg  <= prod;
                default: p3_reg  <= prod;
            endcase
        end
        if (form_en) begin
            rn_reg    <= rn_comb;
            rd_reg    <= rd_comb;
            less_reg  <= (lhs_reg < rhs_reg);
            equal_reg <= (lhs_reg == rhs_reg);
        end
    end

endmodule

`default_nettype wire

### rtl/core/rau_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// rau_queue: small register queue between the front and back parts
// no dependencies

module rau_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/rau_back.sv
`timescale 1ns / 1ps
`default_nettype none
// rau_back: binary gcd, division by the gcd, range check and result register
// depends on rau_pkg

module rau_back
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       q_valid,
    input  wire logic [2*VALUE_WIDTH-1:0]   q_mag,
    input  wire logic [2*VALUE_WIDTH-1:0]   q_dmag,
    input  wire rau_flags_t                 q_flags,
    output logic                            q_pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [NUM_W-1:0]                m_result_num,
    output logic [DEN_W-1:0]                m_result_den,
    output logic                            m_first_less,
    output logic                            m_both_equal,
    output logic                            m_zero_divisor,
    output logic                            m_overflow
);

    localparam int MAG_W = 2 * VALUE_WIDTH;
    localparam int CNT_W = $clog2(MAG_W);
    localparam logic [MAG_W-1:0] MAG_ONE = {{(MAG_W-1){1'b0}}, 1'b1};
    localparam logic [MAG_W-1:0] NUM_LIM = MAG_ONE << (VALUE_WIDTH - 1);
    localparam logic [DEN_W-1:0] DEN_ONE = {{(DEN_W-1){1'b0}}, 1'b1};

    rau_back_state_t state_reg, state_next;

    logic [MAG_W-1:0] x_reg, x_next;
    logic [MAG_W-1:0] y_reg, y_next;
    logic [MAG_W-1:0] n_reg, n_next;
    logic [MAG_W-1:0] d_reg, d_next;
    logic [MAG_W-1:0] rem_n_reg, rem_n_next;
    logic [MAG_W-1:0] rem_d_reg, rem_d_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rau_flags_t       flags_reg, flags_next;

    logic             m_valid_reg, m_valid_next;
    logic [NUM_W-1:0] num_out_reg;
    logic [DEN_W-1:0] den_out_reg;
    logic             less_out_reg, equal_out_reg, zdiv_out_reg, ovf_out_reg;

    logic             out_free, out_load;
    logic             mag_zero, x_eq_y, x_gt_y;
    logic [MAG_W-1:0] diff;
    logic [MAG_W:0]   tn, td, tn_sub, td_sub;
    logic             n_fit, d_fit;
    logic             num_ovf, den_ovf, ovf;
    logic signed [VALUE_WIDTH-1:0] res_small;

    assign mag_zero = (q_mag == '0);
    assign out_free = !m_valid_reg || m_ready;

    // gcd step: compare, and replace the larger odd value by the difference
    assign x_eq_y = (x_reg == y_reg);
    assign x_gt_y = (x_reg > y_reg);
    assign diff   = x_gt_y ? (x_reg - y_reg) : (y_reg - x_reg);

    // restoring division step, both quotients share the divisor in x_reg
    always_comb begin
        tn     = {rem_n_reg, n_reg[MAG_W-1]};
        td     = {rem_d_reg, d_reg[MAG_W-1]};
        tn_sub = tn - {1'b0, x_reg};
        td_sub = td - {1'b0, x_reg};
        n_fit  = (tn >= {1'b0, x_reg});
        d_fit  = (td >= {1'b0, x_reg});
    end

    // range check of the reduced fraction
    always_comb begin
        num_ovf   = flags_reg.neg ? (n_reg > NUM_LIM) : (n_reg >= NUM_LIM);
        den_ovf   = (d_reg >= NUM_LIM);
        ovf       = num_ovf || den_ovf;
        res_small = flags_reg.neg ? -n_reg[VALUE_WIDTH-1:0] : n_reg[VALUE_WIDTH-1:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    state_next = (q_flags.zdiv || mag_zero) ? BK_DONE : BK_GCD;
                end
            end
            BK_GCD: begin
                if (x_eq_y) begin
                    state_next = (x_reg == MAG_ONE) ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        q_pop    = (state_reg == BK_IDLE) && q_valid;
        out_load = (state_reg == BK_DONE) && out_free;
    end

    // datapath next values
    always_comb begin
        x_next     = x_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        rem_n_next = rem_n_reg;
        rem_d_next = rem_d_reg;
        cnt_next   = cnt_reg;
        flags_next = flags_reg;
        case (state_reg)
            BK_IDLE: begin
                x_next         = q_mag;
                y_next         = q_dmag;
                n_next         = q_mag;
                d_next         = (q_flags.zdiv || mag_zero) ? MAG_ONE : q_dmag;
                flags_next     = q_flags;
                flags_next.neg = q_flags.neg && !mag_zero;
            end
            BK_GCD: begin
                if (x_eq_y) begin
                    rem_n_next = '0;
                    rem_d_next = '0;
                    cnt_next   = CNT_W'(MAG_W - 1);
                end else if (!x_reg[0] && !y_reg[0]) begin
                    // common factor of two leaves the fraction too
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    n_next = n_reg >> 1;
                    d_next = d_reg >> 1;
                end else if (!x_reg[0]) begin
                    x_next = x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_next = y_reg >> 1;
                end else if (x_gt_y) begin
                    x_next = diff;
                end else begin
                    y_next = diff;
                end
            end
            BK_DIV: begin
                rem_n_next = n_fit ? tn_sub[MAG_W-1:0] : tn[MAG_W-1:0];
                rem_d_next = d_fit ? td_sub[MAG_W-1:0] : td[MAG_W-1:0];
                n_next     = {n_reg[MAG_W-2:0], n_fit};
                d_next     = {d_reg[MAG_W-2:0], d_fit};
                cnt_next   = cnt_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        rem_n_reg <= rem_n_next;
        rem_d_reg <= rem_d_next;
        cnt_reg   <= cnt_next;
        flags_reg <= flags_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            num_out_reg   <= ovf ? '0 : NUM_W'(res_small);
            den_out_reg   <= ovf ? DEN_ONE : DEN_W'(d_reg[VALUE_WIDTH-2:0]);
            less_out_reg  <= flags_reg.first_less;
            equal_out_reg <= flags_reg.both_equal;
            zdiv_out_reg  <= flags_reg.zdiv;
            ovf_out_reg   <= ovf;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_num   = num_out_reg;
    assign m_result_den   = den_out_reg;
    assign m_first_less   = less_out_reg;
    assign m_both_equal   = equal_out_reg;
    assign m_zero_divisor = zdiv_out_reg;
    assign m_overflow     = ovf_out_reg;

endmodule

`default_nettype wire

### rtl/core/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// rational_arithmetic_unit: top level, front part, request queue and back part
// depends on rau_pkg, rau_front, rau_queue, rau_back
//
//  channel   dir   handshake           payload
//  s_        in    s_valid / s_ready   s_command, s_a_num, s_a_den, s_b_num, s_b_den
//  m_        out   m_valid / m_ready   m_result_num, m_result_den, m_first_less,
//                                      m_both_equal, m_zero_divisor, m_overflow
//
// the front takes one request at a time (4 passes of one shared multiplier, form, push)
// the back sets the rate and also takes one request at a time: a load, the binary gcd
// loop (one shift or subtract a cycle), the division by the gcd and the result load;
// zero numerators and zero divisors skip the gcd and division, a power-of-two gcd
// skips the division; reset is synchronous and active low; a 2-entry queue lets the
// front keep accepting while the back works, and the result register holds while
// m_ready is low

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CMD_W-1:0]  s_command,
    input  wire logic [NUM_W-1:0]  s_a_num,
    input  wire logic [DEN_W-1:0]  s_a_den,
    input  wire logic [NUM_W-1:0]  s_b_num,
    input  wire logic [DEN_W-1:0]  s_b_den,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [NUM_W-1:0]       m_result_num,
    output logic [DEN_W-1:0]       m_result_den,
    output logic                   m_first_less,
    output logic                   m_both_equal,
    output logic                   m_zero_divisor,
    output logic                   m_overflow
);

    localparam int MAG_W       = 2 * VALUE_WIDTH;
    localparam int FLAG_W      = $bits(rau_flags_t);
    localparam int ENTRY_W     = 2 * MAG_W + FLAG_W;
    localparam int QUEUE_DEPTH = 2;

    logic               q_push, q_full, q_pop, q_valid;
    logic [MAG_W-1:0]   f_mag, f_dmag, q_mag, q_dmag;
    rau_flags_t         f_flags, q_flags;
    logic [ENTRY_W-1:0] q_wdata, q_rdata;

    // request intake and raw fraction
    rau_front #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_a_num    (s_a_num),
        .s_a_den    (s_a_den),
        .s_b_num    (s_b_num),
        .s_b_den    (s_b_den),
        .push       (q_push),
        .q_full     (q_full),
        .push_mag   (f_mag),
        .push_dmag  (f_dmag),
        .push_flags (f_flags)
    );

    // pack and unpack queue entries
    assign q_wdata = {f_mag, f_dmag, f_flags};
    assign q_mag   = q_rdata[ENTRY_W-1 -: MAG_W];
    assign q_dmag  = q_rdata[FLAG_W +: MAG_W];
    assign q_flags = rau_flags_t'(q_rdata[FLAG_W-1:0]);

    rau_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_rdata)
    );

    // reduction and result
    rau_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_mag          (q_mag),
        .q_dmag         (q_dmag),
        .q_flags        (q_flags),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_num   (m_result_num),
        .m_result_den   (m_result_den),
        .m_first_less   (m_first_less),
        .m_both_equal   (m_both_equal),
        .m_zero_divisor (m_zero_divisor),
        .m_overflow     (m_overflow)
    );

`ifndef ASSERT_OFF
    // queue is never written while full
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue written while full");

    // back only pops a filled queue
    a_no_underrun: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // an overflowed result reads as zero over one
    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> (m_result_num == '0 && m_result_den == DEN_W'(1)))
        else $error("overflow result is not zero over one");

    // a zero divisor leaves the denominator at one
    a_zdiv_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_divisor) |-> (m_result_den == DEN_W'(1)))
        else $error("zero divisor result has denominator other than one");
`endif

endmodule

`default_nettype wire

### tb/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
// rational_arithmetic_unit_checker: watches both channels of the rational unit, predicts
// each result from the accepted request and compares it field by field; depends on rau_pkg

module rational_arithmetic_unit_checker
    import rau_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_ready,
    input  wire logic [CMD_W-1:0] s_command,
    input  wire logic [NUM_W-1:0] s_a_num,
    input  wire logic [DEN_W-1:0] s_a_den,
    input  wire logic [NUM_W-1:0] s_b_num,
    input  wire logic [DEN_W-1:0] s_b_den,
    input  wire logic             m_valid,
    input  wire logic             m_ready,
    input  wire logic [NUM_W-1:0] m_result_num,
    input  wire logic [DEN_W-1:0] m_result_den,
    input  wire logic             m_first_less,
    input  wire logic             m_both_equal,
    input  wire logic             m_zero_divisor,
    input  wire logic             m_overflow,
    output int                    failures,
    output int                    outstanding,
    output int                    results_checked,
    output int                    zero_divisor_seen,
    output int                    overflow_seen
);

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             first_less;
        logic             both_equal;
        logic             zero_divisor;
        logic             overflow;
    } fraction_result_t;

    // reduced fractions still owed by the unit, oldest first
    fraction_result_t fractions_in_flight[$];

    int fail_total;
    int checked_total;
    int zdiv_total;
    int ovf_total;

    // low VALUE_WIDTH bits as a two's complement numerator
    function automatic longint numerator_value(logic [NUM_W-1:0] raw);
        longint unsigned bits;
        bits = 64'(raw) & ((64'd1 << VALUE_WIDTH) - 64'd1);
        if (bits[VALUE_WIDTH-1])
            return longint'(bits) - (longint'(1) << VALUE_WIDTH);
        return longint'(bits);
    endfunction

    // low VALUE_WIDTH-1 bits as a denominator, zero read as one
    function automatic longint denominator_value(logic [DEN_W-1:0] raw);
        longint unsigned bits;
        bits = 64'(raw) & ((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);
        return (bits == 0) ? longint'(1) : longint'(bits);
    endfunction

    // raw fraction for the command, sign normalised, gcd reduced, range checked
    function automatic fraction_result_t evaluate_rational(
        logic [CMD_W-1:0] cmd,
        logic [NUM_W-1:0] a_num_raw,
        logic [DEN_W-1:0] a_den_raw,
        logic [NUM_W-1:0] b_num_raw,
        logic [DEN_W-1:0] b_den_raw
    );
        longint           an, ad, bn, bd;
        longint           cross_a, cross_b;
        longint           raw_num, raw_den;
        longint unsigned  mag, dmag, x, y, t, lim;
        logic             neg, zdiv, ovf;
        fraction_result_t r;

        an      = numerator_value(a_num_raw);
        ad      = denominator_value(a_den_raw);
        bn      = numerator_value(b_num_raw);
        bd      = denominator_value(b_den_raw);
        cross_a = an * bd;
        cross_b = bn * ad;
        zdiv    = 1'b0;
        ovf     = 1'b0;

        case (cmd)
            CMD_ADD: begin raw_num = cross_a + cross_b; raw_den = ad * bd; end
            CMD_SUB: begin raw_num = cross_a - cross_b; raw_den = ad * bd; end
            CMD_MUL: begin raw_num = an * bn;           raw_den = ad * bd; end
            CMD_DIV: begin raw_num = cross_a;           raw_den = ad * bn; end
            CMD_INC: begin raw_num = an + ad;           raw_den = ad;      end
            CMD_DEC: begin raw_num = an - ad;           raw_den = ad;      end
            default: begin raw_num = 0;                 raw_den = 1;       end
        endcase

        // a negative denominator hands its sign to the numerator
        neg = (raw_num < 0);
        mag = neg ? -raw_num : raw_num;
        if (raw_den < 0) begin
            neg  = !neg;
            dmag = -raw_den;
        end else begin
            dmag = raw_den;
        end

        // zero denominator leaves the numerator unreduced over one
        if (dmag == 0) begin
            zdiv = 1'b1;
            dmag = 1;
        end else begin
            x = mag;
            y = dmag;
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            mag  = mag / x;
            dmag = dmag / x;
        end
        if (mag == 0)
            neg = 1'b0;

        lim = 64'd1 << (VALUE_WIDTH - 1);
        if (neg ? (mag > lim) : (mag > lim - 1))
            ovf = 1'b1;
        if (dmag > lim - 1)
            ovf = 1'b1;
        if (ovf) begin
            neg  = 1'b0;
            mag  = 0;
            dmag = 1;
        end

        r.num          = NUM_W'(neg ? (64'd0 - mag) : mag);
        r.den          = DEN_W'(dmag);
        r.first_less   = (cross_a < cross_b);
        r.both_equal   = (cross_a == cross_b);
        r.zero_divisor = zdiv;
        r.overflow     = ovf;
        return r;
    endfunction

    // results are matched before the same-edge request is queued
    always @(posedge aclk) begin : watch_channels
        fraction_result_t got;
        fraction_result_t want;
        if (!aresetn) begin
            fractions_in_flight.delete();
            fail_total    = 0;
            checked_total = 0;
            zdiv_total    = 0;
            ovf_total     = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_result_num, m_result_den, m_first_less, m_both_equal,
                        m_zero_divisor, m_overflow};
                if (got.zero_divisor) zdiv_total++;
                if (got.overflow) ovf_total++;
                if (fractions_in_flight.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10)
                        $display("%t unexpected result %0d/%0d lt=%b eq=%b zdiv=%b ovf=%b",
                                 $realtime, $signed(got.num), got.den, got.first_less,
                                 got.both_equal, got.zero_divisor, got.overflow);
                end else begin
                    want = fractions_in_flight.pop_front();
                    checked_total++;
                    if (got.num !== want.num || got.den !== want.den
                        || got.first_less !== want.first_less
                        || got.both_equal !== want.both_equal
                        || got.zero_divisor !== want.zero_divisor
                        || got.overflow !== want.overflow) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%t result %0d mismatch", $realtime, checked_total);
                            $display("  expected %0d/%0d lt=%b eq=%b zdiv=%b ovf=%b",
                                     $signed(want.num), want.den, want.first_less,
                                     want.both_equal, want.zero_divisor, want.overflow);
                            $display("  actual   %0d/%0d lt=%b eq=%b zdiv=%b ovf=%b",
                                     $signed(got.num), got.den, got.first_less,
                                     got.both_equal, got.zero_divisor, got.overflow);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                fractions_in_flight.push_back(evaluate_rational(s_command, s_a_num, s_a_den,
                                                                s_b_num, s_b_den));
        end
        failures          <= fail_total;
        outstanding       <= fractions_in_flight.size();
        results_checked   <= checked_total;
        zero_divisor_seen <= zdiv_total;
        overflow_seen     <= ovf_total;
    end

endmodule

### tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// rational_arithmetic_unit_tb: drives directed and random requests into the rational unit
// with bursty input, stalling output and one long hold-off; depends on rau_pkg and the checker

module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int VALUE_WIDTH = 32;

    localparam logic [NUM_W-1:0] NUM_MIN = 32'h8000_0000;
    localparam logic [NUM_W-1:0] NUM_MAX = 32'h7FFF_FFFF;
    localparam logic [DEN_W-1:0] DEN_MAX = 31'h7FFF_FFFF;

    // command codes the unit does not define
    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    localparam int RANDOM_REQUESTS = 600;
    localparam int HOLD_OFF_AT     = 150;
    localparam int HOLD_OFF_CYCLES = 2000;
    localparam int TAIL_CYCLES     = 400;
    localparam int IDLE_LIMIT      = 20000;

    typedef enum int {
        RX_OPEN,
        RX_MOSTLY_READY,
        RX_SPARSE,
        RX_LONG_STALLS
    } rx_mode_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [CMD_W-1:0] s_command = '0;
    logic [NUM_W-1:0] s_a_num   = '0;
    logic [DEN_W-1:0] s_a_den   = 31'd1;
    logic [NUM_W-1:0] s_b_num   = '0;
    logic [DEN_W-1:0] s_b_den   = 31'd1;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [NUM_W-1:0] m_result_num;
    logic [DEN_W-1:0] m_result_den;
    logic             m_first_less;
    logic             m_both_equal;
    logic             m_zero_divisor;
    logic             m_overflow;

    int failures;
    int outstanding;
    int results_checked;
    int zero_divisor_seen;
    int overflow_seen;

    int requests_sent = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    bit hold_off_req  = 1'b0;
    bit hold_off_done = 1'b0;

    rational_arithmetic_unit #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_a_num       (s_a_num),
        .s_a_den       (s_a_den),
        .s_b_num       (s_b_num),
        .s_b_den       (s_b_den),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_num  (m_result_num),
        .m_result_den  (m_result_den),
        .m_first_less  (m_first_less),
        .m_both_equal  (m_both_equal),
        .m_zero_divisor(m_zero_divisor),
        .m_overflow    (m_overflow)
    );

    rational_arithmetic_unit_checker #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_a_num          (s_a_num),
        .s_a_den          (s_a_den),
        .s_b_num          (s_b_num),
        .s_b_den          (s_b_den),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_num     (m_result_num),
        .m_result_den     (m_result_den),
        .m_first_less     (m_first_less),
        .m_both_equal     (m_both_equal),
        .m_zero_divisor   (m_zero_divisor),
        .m_overflow       (m_overflow),
        .failures         (failures),
        .outstanding      (outstanding),
        .results_checked  (results_checked),
        .zero_divisor_seen(zero_divisor_seen),
        .overflow_seen    (overflow_seen)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // numerators: mostly small so fractions reduce, with full range and the extremes
    function automatic logic [NUM_W-1:0] rand_numerator();
        case ($urandom_range(0, 9))
            0, 1, 2: return NUM_W'(int'($urandom_range(0, 40)) - 20);
            3:       return NUM_W'((int'($urandom_range(0, 200)) - 100) * 6);
            4, 5:    return NUM_W'(int'($urandom_range(0, 65535)) - 32768);
            6, 7:    return NUM_W'($urandom);
            default: begin
                case ($urandom_range(0, 4))
                    0:       return NUM_MIN;
                    1:       return NUM_MAX;
                    2:       return '0;
                    3:       return '1;
                    default: return NUM_W'(1);
                endcase
            end
        endcase
    endfunction

    // denominators: mostly small, some wide, some at the top of the range
    function automatic logic [DEN_W-1:0] rand_denominator();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DEN_W'($urandom_range(1, 24));
            5, 6:          return DEN_W'($urandom_range(1, 65535));
            7, 8:          return DEN_W'($urandom_range(1, 32'h7FFF_FFFF));
            default: begin
                case ($urandom_range(0, 2))
                    0:       return DEN_W'(1);
                    1:       return DEN_MAX;
                    default: return DEN_W'(32'h4000_0000);
                endcase
            end
        endcase
    endfunction

    // one request; bursts of random length separated by random gaps
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [NUM_W-1:0] a_num, input logic [DEN_W-1:0] a_den,
                                input logic [NUM_W-1:0] b_num, input logic [DEN_W-1:0] b_den);
        int gap;
        if (burst_left == 0) begin
            case ($urandom_range(0, 4))
                0, 1:    gap = 0;
                2, 3:    gap = $urandom_range(1, 12);
                default: gap = $urandom_range(13, 250);
            endcase
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_a_num   <= a_num;
        s_a_den   <= a_den;
        s_b_num   <= b_num;
        s_b_den   <= b_den;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        requests_sent++;
        if (requests_sent == HOLD_OFF_AT)
            hold_off_req = 1'b1;
    endtask

    // result side: modes of stalling, plus one long hold-off to fill the unit
    initial begin : drive_ready
        rx_mode_t mode;
        int       mode_left;
        int       stall_left;
        mode       = RX_OPEN;
        mode_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(500, 4000);
                end
                mode_left--;
                case (mode)
                    RX_OPEN:         m_ready <= 1'b1;
                    RX_MOSTLY_READY: m_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            m_ready <= 1'b0;
                        end else begin
                            m_ready <= 1'b1;
                            if ($urandom_range(0, 9) == 0)
                                stall_left = $urandom_range(5, 300);
                        end
                    end
                endcase
            end
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results outstanding",
                     idle_cycles, outstanding);
            $display("rational_arithmetic_unit_tb: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CMD_W-1:0] cmd;
        logic [NUM_W-1:0] a_num;
        logic [NUM_W-1:0] b_num;
        logic [DEN_W-1:0] a_den;
        logic [DEN_W-1:0] b_den;
        int               directed_count;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every command, sign handling, zero cases and range limits
        send_request(CMD_ADD, 32'sd1, 31'd2, 32'sd1, 31'd3);
        send_request(CMD_SUB, 32'sd1, 31'd2, 32'sd2, 31'd4);
        send_request(CMD_MUL, -32'sd3, 31'd4, 32'sd2, 31'd9);
        send_request(CMD_DIV, 32'sd3, 31'd4, -32'sd3, 31'd8);
        send_request(CMD_DIV, 32'sd5, 31'd7, 32'sd0, 31'd3);
        send_request(CMD_DIV, 32'sd0, 31'd5, 32'sd0, 31'd7);
        send_request(CMD_INC, -32'sd7, 31'd3, 32'sd1, 31'd1);
        send_request(CMD_DEC, 32'sd7, 31'd3, 32'sd7, 31'd3);
        send_request(CMD_DEC, NUM_MIN, 31'd1, 32'sd0, 31'd1);
        send_request(CMD_INC, NUM_MAX, 31'd1, NUM_MAX, 31'd1);
        send_request(CMD_ADD, NUM_MAX, 31'd1, NUM_MAX, 31'd1);
        send_request(CMD_ADD, NUM_MAX, 31'd1, NUM_MIN, 31'd1);
        send_request(CMD_MUL, NUM_MIN, 31'd1, NUM_MIN, 31'd1);
        send_request(CMD_MUL, NUM_MIN, 31'd1, -32'sd1, 31'd1);
        send_request(CMD_MUL, NUM_MIN, 31'd1, 32'sd1, 31'd1);
        send_request(CMD_MUL, 32'sd1, DEN_MAX, 32'sd1, 31'd2);
        send_request(CMD_MUL, NUM_MAX, DEN_MAX, NUM_MAX, DEN_MAX);
        send_request(CMD_SUB, NUM_MIN, DEN_MAX, NUM_MAX, DEN_MAX);
        send_request(CMD_DIV, NUM_MIN, 31'd1, 32'sd0, DEN_MAX);
        send_request(CMD_DIV, -32'sd1, 31'd1, NUM_MIN, 31'd1);
        // zero denominators are read as one
        send_request(CMD_ADD, 32'sd3, 31'd0, 32'sd1, 31'd2);
        send_request(CMD_SUB, 32'sd4, 31'd6, 32'sd2, 31'd0);
        // undefined commands still report the comparison
        send_request(CMD_SPARE_LO, -32'sd5, 31'd3, 32'sd2, 31'd7);
        send_request(CMD_SPARE_HI, 32'sd2, 31'd4, 32'sd1, 31'd2);
        directed_count = requests_sent;

        // random requests; some pairs of equal value to hit the equality flag
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            cmd   = CMD_W'($urandom_range(0, 5));
            a_num = rand_numerator();
            a_den = rand_denominator();
            if ($urandom_range(0, 9) == 0) begin
                b_num = a_num;
                b_den = a_den;
            end else begin
                b_num = rand_numerator();
                b_den = rand_denominator();
            end
            send_request(cmd, a_num, a_den, b_num, b_den);
        end
        s_valid <= 1'b0;

        // drain, then watch for stray results
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("summary: %0d requests (%0d directed), %0d results checked, %0d mismatches",
                 requests_sent, directed_count, results_checked, failures);
        $display("summary: %0d zero-divisor and %0d overflow results, %0d-cycle output hold-off",
                 zero_divisor_seen, overflow_seen, HOLD_OFF_CYCLES);
        if (failures == 0)
            $display("rational_arithmetic_unit_tb: PASS");
        else
            $display("rational_arithmetic_unit_tb: FAIL");
        $finish;
    end

endmodule

### rational_arithmetic_unit.f
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_queue.sv
rtl/core/rau_back.sv
rtl/core/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_checker.sv
tb/rational_arithmetic_unit_tb.sv
